// ===== rtl/core/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape block.
// Used by the front end, the command queue, the back end and the top level.
package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_OPEN = 2'd1;
    localparam logic [1:0] ERR_ESC  = 2'd2;
    localparam logic [1:0] ERR_STR  = 2'd3;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    // UTF-8 framing
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;

    // One decoded input item: up to three results of the same kind
    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] kind;
        logic [1:0] err;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_cmd;

endpackage

// ===== rtl/core/jsu_if.sv =====
// Valid/ready channel interfaces for the JSON string unescape block.
// Standalone; no package dependency.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input error_code,
                    input last, output ready);
endinterface

// ===== rtl/core/json_string_unescape.sv =====
// Top level of the streaming JSON string unescaper.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue and jsu_back.
//
//   port   dir  fields                                   accepted when
//   i_in   in   in_byte[7:0]                             valid && ready
//   o_out  out  out_byte[7:0] kind[1:0] error_code[1:0]  valid && ready
//               last
//
// One input byte per cycle when the output is drained; each result leaves
// through the output register one per cycle, so a \u escape giving three
// bytes holds the output for all three of them. The command queue (QUEUE_DEPTH
// entries) lets input keep flowing while the output stalls; input stalls
// only when the queue is full. Synchronous active-low reset returns the parser
// to waiting for an opening quote and empties the queue.
module json_string_unescape
    import jsu_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    logic q_full, q_empty, q_push, q_pop;
    t_cmd push_cmd, head_cmd;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    jsu_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_cmd),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/core/jsu_front.sv =====
// Front end: accepts input bytes, tracks the string parse state and turns
// each byte that completes an item into one result command. Depends on jsu_pkg and jsu_in_if.
module jsu_front
    import jsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    jsu_in_if.sink  i_in,
    input  logic    i_q_full,
    output logic    o_push,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        PH_OPEN = 4'b0001,
        PH_BODY = 4'b0010,
        PH_ESC  = 4'b0100,
        PH_HEX  = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_point, n_code_point;
    logic        r_hex_stopped, n_hex_stopped;

    logic        acc;
    logic [7:0]  c;
    logic        is_hex;
    logic [3:0]  hv;
    logic [15:0] cp_next;

    assign i_in.ready = !i_q_full;
    assign acc        = i_in.valid && !i_q_full;
    assign c          = i_in.in_byte;

    always_comb begin
        is_hex = 1'b1;
        hv     = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hv = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            hv = c[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign cp_next = (!r_hex_stopped && is_hex) ? {r_code_point[11:0], hv} : r_code_point;

    always_comb begin
        n_phase       = r_phase;
        n_hex_count   = r_hex_count;
        n_code_point  = r_code_point;
        n_hex_stopped = r_hex_stopped;
        o_push        = 1'b0;
        o_cmd         = '0;
        o_cmd.cnt     = 2'd1;
        if (acc) begin
            unique case (r_phase)
                PH_OPEN: begin
                    if (c == CH_QUOTE) begin
                        n_phase = PH_BODY;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_ERR;
                        o_cmd.err  = ERR_OPEN;
                    end
                end
                PH_BODY: begin
                    if (c == CH_NUL) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_ERR;
                        o_cmd.err  = ERR_STR;
                        n_phase    = PH_OPEN;
                    end else if (c == CH_QUOTE) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_END;
                        n_phase    = PH_OPEN;
                    end else if (c == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        o_push   = 1'b1;
                        o_cmd.b0 = c;
                    end
                end
                PH_ESC: begin
                    if (c == CH_NUL) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_ERR;
                        o_cmd.err  = ERR_ESC;
                        n_phase    = PH_OPEN;
                    end else if (c == CH_U) begin
                        n_hex_count   = 2'd0;
                        n_code_point  = '0;
                        n_hex_stopped = 1'b0;
                        n_phase       = PH_HEX;
                    end else begin
                        o_push  = 1'b1;
                        n_phase = PH_BODY;
                        case (c)
                            CH_B:    o_cmd.b0 = 8'h08;
                            CH_F:    o_cmd.b0 = 8'h0C;
                            CH_N:    o_cmd.b0 = 8'h0A;
                            CH_R:    o_cmd.b0 = 8'h0D;
                            CH_T:    o_cmd.b0 = 8'h09;
                            default: o_cmd.b0 = c;
                        endcase
                    end
                end
                PH_HEX: begin
                    if (c == CH_NUL) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_ERR;
                        o_cmd.err  = ERR_STR;
                        n_phase    = PH_OPEN;
                    end else begin
                        n_code_point = cp_next;
                        if (r_hex_stopped || !is_hex) begin
                            n_hex_stopped = 1'b1;
                        end
                        if (r_hex_count == 2'd3) begin
                            // fourth character: emit the code point as UTF-8
                            o_push      = 1'b1;
                            n_hex_count = 2'd0;
                            n_phase     = PH_BODY;
                            if (cp_next[15:7] == '0) begin
                                o_cmd.b0 = cp_next[7:0];
                            end else if (cp_next[15:11] == '0) begin
                                o_cmd.cnt = 2'd2;
                                o_cmd.b0  = UTF_LEAD2 | {3'b000, cp_next[10:6]};
                                o_cmd.b1  = UTF_CONT | {2'b00, cp_next[5:0]};
                            end else begin
                                o_cmd.cnt = 2'd3;
                                o_cmd.b0  = UTF_LEAD3 | {4'b0000, cp_next[15:12]};
                                o_cmd.b1  = UTF_CONT | {2'b00, cp_next[11:6]};
                                o_cmd.b2  = UTF_CONT | {2'b00, cp_next[5:0]};
                            end
                        end else begin
                            n_hex_count = r_hex_count + 2'd1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_OPEN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OPEN;
            r_hex_count   <= 2'd0;
            r_code_point  <= '0;
            r_hex_stopped <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_hex_count   <= n_hex_count;
            r_code_point  <= n_code_point;
            r_hex_stopped <= n_hex_stopped;
        end
    end

endmodule

// ===== rtl/core/jsu_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on jsu_pkg for the command type.
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/jsu_back.sv =====
// Back end: takes commands from the queue and plays out their results one
// per cycle into the output register, pausing while the output stalls. Depends on jsu_pkg and jsu_out_if.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    jsu_out_if.source  o_out
);

    t_cmd       r_cur;
    logic       r_cur_valid;
    logic [1:0] r_idx;

    logic       r_ov;
    logic [7:0] r_byte;
    logic [1:0] r_kind;
    logic [1:0] r_err;
    logic       r_last;

    logic       out_free;
    logic       emit;
    logic       is_last;
    logic [7:0] sel_byte;

    assign out_free = !r_ov || o_out.ready;
    assign emit     = r_cur_valid && out_free;
    assign is_last  = (r_idx == r_cur.cnt - 2'd1);
    assign o_pop    = !i_empty && (!r_cur_valid || (emit && is_last));

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = r_cur.b0;
            2'd1:    sel_byte = r_cur.b1;
            default: sel_byte = r_cur.b2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (emit) begin
            r_byte <= sel_byte;
            r_kind <= r_cur.kind;
            r_err  <= r_cur.err;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_ov        <= 1'b0;
        end else begin
            if (emit) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_idx       <= 2'd0;
            end else if (emit) begin
                if (is_last) begin
                    r_cur_valid <= 1'b0;
                    r_idx       <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_byte;
    assign o_out.kind       = r_kind;
    assign o_out.error_code = r_err;
    assign o_out.last       = r_last;

endmodule
